// ===== hdl/prc_pkg.sv =====
// Shared types and codes for the pump run controller.
`default_nettype none

package prc_pkg;

    // Item kinds carried on the input channel's tuser
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_RUN  = 2'd3
    } op_t;

    // Reason the pump stopped during an item
    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_VOLUME = 2'd1,
        CAUSE_TMO    = 2'd2,
        CAUSE_MANUAL = 2'd3
    } cause_t;

    // Register indexes on the configuration port
    localparam logic REG_MIN_ON  = 1'b0;
    localparam logic REG_MIN_OFF = 1'b1;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned TDATA_IN_W = 64;
    localparam int unsigned TDATA_OUT_W = 8;

    typedef struct packed {
        logic [15:0] min_on_time;
        logic [15:0] min_off_time;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] dispensed_volume;
        logic [15:0] run_volume;
        logic [31:0] run_timeout;
    } item_t;

    typedef struct packed {
        logic   pump_on;
        logic   flow_reset;
        cause_t stop_cause;
        logic   refused;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/prc_apb_regs.sv =====
// APB register bank holding the minimum on and off times.
`default_nettype none

module prc_apb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [prc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output prc_pkg::cfg_t                      cfg
);

    logic [15:0] min_on_reg;
    logic [15:0] min_off_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes; word index is address bit 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_on_reg  <= '0;
            min_off_reg <= '0;
        end else if (wr_en) begin
            if (paddr[2] == prc_pkg::REG_MIN_OFF) begin
                min_off_reg <= pwdata[15:0];
            end else begin
                min_on_reg <= pwdata[15:0];
            end
        end
    end

    // Read mux
    always_comb begin
        if (paddr[2] == prc_pkg::REG_MIN_OFF) begin
            prdata = {16'd0, min_off_reg};
        end else begin
            prdata = {16'd0, min_on_reg};
        end
    end

    assign cfg.min_on_time  = min_on_reg;
    assign cfg.min_off_time = min_off_reg;

endmodule

`default_nettype wire

// ===== hdl/prc_core.sv =====
// Pump state registers and the per-item lockout and auto-stop logic.
`default_nettype none

module prc_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire prc_pkg::item_t  item,
    input  wire prc_pkg::cfg_t   cfg,
    output prc_pkg::result_t     result
);

    logic [31:0] now_reg, now_next;
    logic [31:0] last_on_reg, last_on_next;
    logic [31:0] last_off_reg, last_off_next;
    logic        ever_stopped_reg, ever_stopped_next;
    logic        running_reg, running_next;
    logic        vol_armed_reg, vol_armed_next;
    logic        dl_armed_reg, dl_armed_next;
    logic [15:0] target_reg, target_next;
    logic [31:0] deadline_reg, deadline_next;

    logic [31:0] t_now;
    logic [31:0] off_elapsed;
    logic [31:0] on_elapsed;
    logic [31:0] dl_diff;
    logic        on_lock;
    logic        off_lock;
    logic        vol_hit;
    logic        dl_hit;

    // Time seen by this item: a tick advances the clock first
    assign t_now       = (item.op == prc_pkg::OP_TICK) ? now_reg + 32'd1 : now_reg;
    assign off_elapsed = t_now - last_off_reg;
    assign on_elapsed  = t_now - last_on_reg;
    assign dl_diff     = t_now - deadline_reg;

    // Lockouts; the off-time check only counts once the pump has stopped
    assign on_lock  = ever_stopped_reg && (cfg.min_off_time != 16'd0) &&
                      (off_elapsed < {16'd0, cfg.min_off_time});
    assign off_lock = (cfg.min_on_time != 16'd0) &&
                      (on_elapsed < {16'd0, cfg.min_on_time});

    // Auto-stop conditions; volume wins over the deadline
    assign vol_hit = vol_armed_reg && (item.dispensed_volume >= target_reg);
    assign dl_hit  = dl_armed_reg && !dl_diff[31];

    always_comb begin
        now_next          = now_reg;
        last_on_next      = last_on_reg;
        last_off_next     = last_off_reg;
        ever_stopped_next = ever_stopped_reg;
        running_next      = running_reg;
        vol_armed_next    = vol_armed_reg;
        dl_armed_next     = dl_armed_reg;
        target_next       = target_reg;
        deadline_next     = deadline_reg;
        result.flow_reset = 1'b0;
        result.stop_cause = prc_pkg::CAUSE_NONE;
        result.refused    = 1'b0;

        case (item.op)
            prc_pkg::OP_TICK: begin
                now_next = t_now;
                if (running_reg && (vol_hit || dl_hit)) begin
                    // Run is disarmed even when the stop is refused
                    vol_armed_next = 1'b0;
                    dl_armed_next  = 1'b0;
                    if (off_lock) begin
                        result.refused = 1'b1;
                    end else begin
                        running_next      = 1'b0;
                        last_off_next     = t_now;
                        ever_stopped_next = 1'b1;
                        result.stop_cause = vol_hit ? prc_pkg::CAUSE_VOLUME
                                                    : prc_pkg::CAUSE_TMO;
                    end
                end
            end
            prc_pkg::OP_ON: begin
                if (!running_reg) begin
                    if (on_lock) begin
                        result.refused = 1'b1;
                    end else begin
                        running_next = 1'b1;
                        last_on_next = t_now;
                    end
                end
            end
            prc_pkg::OP_OFF: begin
                if (running_reg) begin
                    if (off_lock) begin
                        result.refused = 1'b1;
                    end else begin
                        running_next      = 1'b0;
                        last_off_next     = t_now;
                        ever_stopped_next = 1'b1;
                        vol_armed_next    = 1'b0;
                        dl_armed_next     = 1'b0;
                        result.stop_cause = prc_pkg::CAUSE_MANUAL;
                    end
                end
            end
            prc_pkg::OP_RUN: begin
                // Arm target and deadline, pulse flow reset, then ask for on
                result.flow_reset = 1'b1;
                target_next       = item.run_volume;
                vol_armed_next    = (item.run_volume != 16'd0);
                dl_armed_next     = (item.run_timeout != 32'd0);
                if (item.run_timeout != 32'd0) begin
                    deadline_next = t_now + item.run_timeout;
                end
                if (!running_reg) begin
                    if (on_lock) begin
                        result.refused = 1'b1;
                    end else begin
                        running_next = 1'b1;
                        last_on_next = t_now;
                    end
                end
            end
            default: begin
                now_next = now_reg;
            end
        endcase

        result.pump_on = running_next;
    end

    // State commits only when the item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg          <= '0;
            last_on_reg      <= '0;
            last_off_reg     <= '0;
            ever_stopped_reg <= 1'b0;
            running_reg      <= 1'b0;
            vol_armed_reg    <= 1'b0;
            dl_armed_reg     <= 1'b0;
            target_reg       <= '0;
            deadline_reg     <= '0;
        end else if (step) begin
            now_reg          <= now_next;
            last_on_reg      <= last_on_next;
            last_off_reg     <= last_off_next;
            ever_stopped_reg <= ever_stopped_next;
            running_reg      <= running_next;
            vol_armed_reg    <= vol_armed_next;
            dl_armed_reg     <= dl_armed_next;
            target_reg       <= target_next;
            deadline_reg     <= deadline_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pump_run_controller.sv =====
// Top level of the pump run controller: input register, core, result register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------
//  s_      | in        | s_tvalid / s_tready    | tuser: op; tdata: volume, target,
//          |           |                        |   timeout
//  m_      | out       | m_tvalid / m_tready    | tdata: pump_on, flow_reset, cause,
//          |           |                        |   refused
//  apb     | in        | psel / penable / pready| min_on_time, min_off_time
//
// One item per cycle sustained while m_tready is high; each item passes through
// the input register and leaves through the result register.
// The single state update per item (clock, lockout times, run arms) sets that rate.
// A stalled m_ side holds the result and the input register fills, then s_tready drops.
// aresetn is synchronous, active low, and empties both registers and clears all state.
`default_nettype none

module pump_run_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [15:0] dispensed_volume, [31:16] run_volume, [63:32] run_timeout
    input  wire logic [prc_pkg::TDATA_IN_W-1:0]    s_tdata,
    // [1:0] op
    input  wire logic [1:0]                        s_tuser,
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] pump_on, [1] flow_reset, [3:2] stop_cause, [4] refused, [7:5] zero
    output logic      [prc_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [prc_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);

    logic             in_valid_reg;
    prc_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    prc_pkg::result_t out_res_reg;
    logic             advance;
    prc_pkg::cfg_t    cfg;
    prc_pkg::result_t core_res;

    prc_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_res)
    );

    // Item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op               <= prc_pkg::op_t'(s_tuser);
            in_item_reg.dispensed_volume <= s_tdata[15:0];
            in_item_reg.run_volume       <= s_tdata[31:16];
            in_item_reg.run_timeout      <= s_tdata[63:32];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.refused, out_res_reg.stop_cause,
                       out_res_reg.flow_reset, out_res_reg.pump_on};

endmodule

`default_nettype wire

// ===== hdl/prc_checker.sv =====
// Port-level checks for the pump run controller, bound to the top level.
`default_nettype none

module prc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [prc_pkg::TDATA_OUT_W-1:0]   m_tdata
);

    // No result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A stop leaves the relay off
    a_stop_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:2] != 2'd0) |-> !m_tdata[0])
        else $error("stop reported with pump still on");

    // A refused request never reports a stop
    a_refused_no_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> (m_tdata[3:2] == 2'd0))
        else $error("stop reported on refused item");

    // A run request cannot stop the pump
    a_run_no_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> (m_tdata[3:2] == 2'd0))
        else $error("stop reported on run request");

endmodule

bind pump_run_controller prc_checker u_prc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pump run controller: stream driver, result monitor, APB set-up.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT       = 300000;
    localparam int ITEMS_PER_SETTING = 220;
    localparam int N_SETTINGS        = 8;
    localparam int LONG_HOLD_AT      = 300;
    localparam int LONG_HOLD_CYCLES  = 80;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [prc_pkg::TDATA_IN_W-1:0]  s_tdata  = '0;
    logic [1:0]                      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [prc_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [prc_pkg::PADDR_W-1:0]     paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    pump_run_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 0;
    end

    // Items waiting to be sent, and results the pump model says are due
    prc_pkg::item_t   pending[$];
    prc_pkg::result_t due_results[$];

    int  mismatches     = 0;
    int  cfg_errors     = 0;
    int  got_results    = 0;
    int  cycles         = 0;
    bit  calm           = 1'b0;
    bit  long_hold_done = 1'b0;
    int  tx_gap         = 0;
    int  rx_stall       = 0;
    prc_pkg::item_t   tx_item;
    prc_pkg::result_t predicted;
    prc_pkg::result_t want;

    // Pump model: limits and controller state
    logic [15:0] lim_on  = 16'd0;
    logic [15:0] lim_off = 16'd0;
    logic [31:0] ms_now       = 32'd0;
    logic [31:0] on_since     = 32'd0;
    logic [31:0] off_since    = 32'd0;
    logic        has_stopped  = 1'b0;
    logic        pump_running = 1'b0;
    logic        vol_armed    = 1'b0;
    logic        tmo_armed    = 1'b0;
    logic [15:0] vol_target   = 16'd0;
    logic [31:0] tmo_deadline = 32'd0;

    // On request, held off by the minimum off-time once the pump has stopped
    task automatic request_start(output logic refused);
        refused = 1'b0;
        if (!pump_running) begin
            if (has_stopped && lim_off != 16'd0 &&
                (ms_now - off_since) < {16'd0, lim_off}) begin
                refused = 1'b1;
            end else begin
                pump_running = 1'b1;
                on_since = ms_now;
            end
        end
    endtask

    // Off request, held off by the minimum on-time
    task automatic request_stop(output logic refused, output logic stopped);
        refused = 1'b0;
        stopped = 1'b0;
        if (pump_running) begin
            if (lim_on != 16'd0 && (ms_now - on_since) < {16'd0, lim_on}) begin
                refused = 1'b1;
            end else begin
                pump_running = 1'b0;
                off_since = ms_now;
                has_stopped = 1'b1;
                vol_armed = 1'b0;
                tmo_armed = 1'b0;
                stopped = 1'b1;
            end
        end
    endtask

    task automatic pump_step(input prc_pkg::item_t it, output prc_pkg::result_t r);
        logic [31:0] past;
        logic        stopped;
        logic        blocked;
        r.pump_on    = 1'b0;
        r.flow_reset = 1'b0;
        r.stop_cause = prc_pkg::CAUSE_NONE;
        r.refused    = 1'b0;
        stopped      = 1'b0;
        blocked      = 1'b0;
        case (it.op)
            prc_pkg::OP_TICK: begin
                // time moves first, run checks use the new time
                ms_now = ms_now + 32'd1;
                past = ms_now - tmo_deadline;
                if (pump_running) begin
                    if (vol_armed && it.dispensed_volume >= vol_target) begin
                        vol_armed = 1'b0;
                        tmo_armed = 1'b0;
                        request_stop(blocked, stopped);
                        if (stopped) r.stop_cause = prc_pkg::CAUSE_VOLUME;
                    end else if (tmo_armed && !past[31]) begin
                        vol_armed = 1'b0;
                        tmo_armed = 1'b0;
                        request_stop(blocked, stopped);
                        if (stopped) r.stop_cause = prc_pkg::CAUSE_TMO;
                    end
                end
            end
            prc_pkg::OP_ON: begin
                request_start(blocked);
            end
            prc_pkg::OP_OFF: begin
                request_stop(blocked, stopped);
                if (stopped) r.stop_cause = prc_pkg::CAUSE_MANUAL;
            end
            prc_pkg::OP_RUN: begin
                r.flow_reset = 1'b1;
                vol_target = it.run_volume;
                vol_armed = (it.run_volume != 16'd0);
                if (it.run_timeout != 32'd0) begin
                    tmo_armed = 1'b1;
                    tmo_deadline = ms_now + it.run_timeout;
                end else begin
                    tmo_armed = 1'b0;
                end
                request_start(blocked);
            end
            default: begin
            end
        endcase
        r.refused = blocked;
        r.pump_on = pump_running;
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom());
    endfunction

    task automatic queue_item(prc_pkg::op_t op, logic [15:0] disp, logic [15:0] vol,
                              logic [31:0] tmo);
        prc_pkg::item_t it;
        it.op               = op;
        it.dispensed_volume = disp;
        it.run_volume       = vol;
        it.run_timeout      = tmo;
        pending.push_back(it);
    endtask

    // One dispensing session: a start, then a rising flow count with stray requests
    task automatic queue_session();
        int          n_ticks;
        int          pick;
        logic [15:0] flow;
        logic [15:0] vol;
        logic [31:0] tmo;
        flow = 16'd0;
        pick = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0, 1, 2: vol = 16'd0;
            3:       vol = rnd16();
            default: vol = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: tmo = 32'd0;
            4, 5:       tmo = $urandom();
            default:    tmo = 32'($urandom_range(1, 50));
        endcase
        if (pick < 2) queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        else queue_item(prc_pkg::OP_RUN, rnd16(), vol, tmo);
        n_ticks = $urandom_range(1, 60);
        for (int k = 0; k < n_ticks; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_item(prc_pkg::OP_OFF, rnd16(), rnd16(), $urandom());
            end else if (pick < 6) begin
                queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
            end else if (pick < 8) begin
                queue_item(prc_pkg::OP_RUN, rnd16(), 16'($urandom_range(0, 30)),
                           32'($urandom_range(0, 40)));
                flow = 16'd0;
            end else if (pick < 11) begin
                // stray meter reading anywhere in range
                queue_item(prc_pkg::OP_TICK, rnd16(), rnd16(), $urandom());
            end else begin
                if (flow < 16'hFFF0) flow = flow + 16'($urandom_range(0, 3));
                queue_item(prc_pkg::OP_TICK, flow, rnd16(), $urandom());
            end
        end
    endtask

    // APB write, then read back the same register
    task automatic apb_write(logic idx, logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'd0, val}) begin
            $error("prdata: expected %h, got %h", {16'd0, val}, prdata);
            cfg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(logic [15:0] on_ms, logic [15:0] off_ms);
        apb_write(prc_pkg::REG_MIN_ON, on_ms);
        apb_write(prc_pkg::REG_MIN_OFF, off_ms);
        lim_on  = on_ms;
        lim_off = off_ms;
        @(negedge aclk);
    endtask

    // Block is idle once nothing is queued, offered or due
    task automatic wait_drained();
        @(negedge aclk);
        while (pending.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Driver: offers queued items, with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pump_step(tx_item, predicted);
                due_results.push_back(predicted);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0) begin
                    tx_item = pending.pop_front();
                    s_tuser  <= tx_item.op;
                    s_tdata  <= {tx_item.run_timeout, tx_item.run_volume,
                                 tx_item.dispensed_volume};
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item and stalls the result side now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_results++;
                if (due_results.size() == 0) begin
                    $error("result item with nothing due: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[0] !== want.pump_on) begin
                        $error("pump_on: expected %0d, got %0d", want.pump_on, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1] !== want.flow_reset) begin
                        $error("flow_reset: expected %0d, got %0d", want.flow_reset, m_tdata[1]);
                        mismatches++;
                    end
                    if (m_tdata[3:2] !== want.stop_cause) begin
                        $error("stop_cause: expected %0d, got %0d", want.stop_cause,
                               m_tdata[3:2]);
                        mismatches++;
                    end
                    if (m_tdata[4] !== want.refused) begin
                        $error("refused: expected %0d, got %0d", want.refused, m_tdata[4]);
                        mismatches++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (got_results == LONG_HOLD_AT && !long_hold_done) begin
                rx_stall = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    logic [15:0] on_tab  [N_SETTINGS] = '{16'd0, 16'd3, 16'hFFFF, 16'd1,
                                          16'd0, 16'd0, 16'hFFFF, 16'd4};
    logic [15:0] off_tab [N_SETTINGS] = '{16'd0, 16'd2, 16'hFFFF, 16'd1,
                                          16'd0, 16'hFFFF, 16'd0, 16'd4};

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_limits(16'd0, 16'd0);

        // no lockouts: redundant requests, run while running, each stop cause
        queue_item(prc_pkg::OP_TICK, 16'd0, rnd16(), $urandom());
        queue_item(prc_pkg::OP_OFF, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'hFFFF, 32'hFFFF_FFFF);
        queue_item(prc_pkg::OP_TICK, 16'hFFFF, rnd16(), $urandom());
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'd0, 32'd1);
        queue_item(prc_pkg::OP_TICK, 16'd0, rnd16(), $urandom());
        // volume and deadline due together: volume wins
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'd2, 32'd1);
        queue_item(prc_pkg::OP_TICK, 16'd2, rnd16(), $urandom());
        queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_OFF, rnd16(), rnd16(), $urandom());
        wait_drained();

        // lockouts: refused on, refused run keeping its arms, refused auto stop
        set_limits(16'd2, 16'd3);
        queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'd4, 32'd0);
        queue_item(prc_pkg::OP_TICK, 16'd9, rnd16(), $urandom());
        queue_item(prc_pkg::OP_TICK, 16'd0, rnd16(), $urandom());
        queue_item(prc_pkg::OP_TICK, 16'd0, rnd16(), $urandom());
        queue_item(prc_pkg::OP_ON, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_OFF, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_TICK, 16'd4, rnd16(), $urandom());
        queue_item(prc_pkg::OP_TICK, 16'd100, rnd16(), $urandom());
        queue_item(prc_pkg::OP_OFF, rnd16(), rnd16(), $urandom());
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'd0, 32'h8000_0000);
        queue_item(prc_pkg::OP_TICK, 16'd0, rnd16(), $urandom());
        queue_item(prc_pkg::OP_RUN, rnd16(), 16'd0, 32'd0);

        // random sessions under each limit setting; the sender waits out each setting
        for (int p = 0; p < N_SETTINGS; p++) begin
            wait_drained();
            if (p == 4) set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
            else set_limits(on_tab[p], off_tab[p]);
            if (p == N_SETTINGS - 1) calm = 1'b1;
            while (pending.size() < ITEMS_PER_SETTING) queue_session();
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && cfg_errors == 0 && due_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
